[rtl/lcgrr_pkg.sv]
// Package for the ranged LCG block: payload types, generator constants and sequencer states.
package lcgrr_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [DATA_W-1:0] LCG_MUL       = 32'd1103515245;
    localparam logic [DATA_W-1:0] LCG_ADD       = 32'd12345;
    localparam int                MIX_SHIFT     = 16;
    localparam int                SEED_DISCARDS = 5;

    // Several advances in a row fold into one affine step: state * m + a.
    function automatic logic [DATA_W-1:0] seed_mul_f();
        logic [DATA_W-1:0] m;
        m = LCG_MUL;
        for (int k = 1; k < SEED_DISCARDS; k++) begin
            m = DATA_W'(m * LCG_MUL);
        end
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] seed_add_f();
        logic [DATA_W-1:0] a;
        a = '0;
        for (int k = 0; k < SEED_DISCARDS; k++) begin
            a = DATA_W'(a * LCG_MUL + LCG_ADD);
        end
        return a;
    endfunction

    localparam logic [DATA_W-1:0] SEED_MUL = seed_mul_f();
    localparam logic [DATA_W-1:0] SEED_ADD = seed_add_f();

    typedef struct packed {
        logic signed [DATA_W-1:0] range_low;
        logic signed [DATA_W-1:0] range_high;
    } t_req;

    typedef struct packed {
        logic        [DATA_W-1:0] raw_value;
        logic signed [DATA_W-1:0] ranged_value;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_OUT
    } t_fsm;

endpackage

[rtl/lcgrr_mac.sv]
// Shared multiply-add unit: low word of a * b + c.
module lcgrr_mac (
    input  logic [lcgrr_pkg::DATA_W-1:0] i_a,
    input  logic [lcgrr_pkg::DATA_W-1:0] i_b,
    input  logic [lcgrr_pkg::DATA_W-1:0] i_c,
    output logic [lcgrr_pkg::DATA_W-1:0] o_y
);
    import lcgrr_pkg::*;

    assign o_y = DATA_W'(i_a * i_b + i_c);

endmodule

[rtl/lcgrr_divider.sv]
// Radix-2 restoring remainder unit, one quotient bit per cycle.
module lcgrr_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lcgrr_pkg::DATA_W-1:0] i_dividend,
    input  logic [lcgrr_pkg::DATA_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [lcgrr_pkg::DATA_W-1:0] o_remainder
);
    import lcgrr_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [DATA_W-1:0]   r_dvd, n_dvd;
    logic [DATA_W-1:0]   r_dvs, n_dvs;
    logic [DATA_W:0]     trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_dvd[DATA_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DATA_W - 1);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so the difference fits.
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = DATA_W'(trial - {1'b0, r_dvs});
            end else begin
                n_rem = trial[DATA_W-1:0];
            end
            n_dvd = {r_dvd[DATA_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

[rtl/lcg_random_with_range.sv]
// Top level of the ranged LCG: generator state, sequencer and result register.
//
//  channel   direction  handshake                  payload
//  cfg       in         i_cfg_we                   i_cfg_wdata (seed)
//  req       in         i_req_valid / o_req_ready  i_req (t_req)
//  rsp       out        o_rsp_valid / i_rsp_ready  o_rsp (t_rsp)
//
// A request passes from its transfer through S_START and the 32 steps of the remainder
// unit to S_OUT; a full-span range skips the unit and goes from S_START to S_OUT.
// The block takes one request at a time and holds ready low until the result is taken.
// A seed write loads the state through the shared multiply-add unit.
// After reset the state equals seed zero advanced five times; there is no clearing pass.
module lcg_random_with_range (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lcgrr_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  lcgrr_pkg::t_req              i_req,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output lcgrr_pkg::t_rsp              o_rsp
);
    import lcgrr_pkg::*;

    t_fsm               r_fsm, n_fsm;
    logic [DATA_W-1:0]  r_gen, n_gen;
    logic [DATA_W-1:0]  r_lo, n_lo;
    logic [DATA_W-1:0]  r_hi, n_hi;
    logic [DATA_W-1:0]  r_raw, n_raw;
    logic [DATA_W-1:0]  r_ranged, n_ranged;
    logic [DATA_W-1:0]  mac_a, mac_b, mac_c, mac_y;
    logic [DATA_W-1:0]  mix;
    logic [DATA_W-1:0]  size;
    logic               req_xfer;
    logic               div_start, div_done;
    logic [DATA_W-1:0]  div_rem;

    assign req_xfer = i_req_valid && o_req_ready;
    assign mix      = r_gen ^ (r_gen >> MIX_SHIFT);
    assign size     = DATA_W'(r_hi - r_lo + 1'b1);

    // The seed write uses the folded five-step form; a request uses one step.
    always_comb begin
        if (i_cfg_we) begin
            mac_a = i_cfg_wdata;
            mac_b = SEED_MUL;
            mac_c = SEED_ADD;
        end else begin
            mac_a = r_gen;
            mac_b = LCG_MUL;
            mac_c = LCG_ADD;
        end
    end

    lcgrr_mac u_mac (
        .i_a (mac_a),
        .i_b (mac_b),
        .i_c (mac_c),
        .o_y (mac_y)
    );

    lcgrr_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (mix),
        .i_divisor   (size),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_fsm       = r_fsm;
        n_gen       = r_gen;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_raw       = r_raw;
        n_ranged    = r_ranged;
        div_start   = 1'b0;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        if (i_cfg_we) begin
            n_gen = mac_y;
        end
        case (r_fsm)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (req_xfer) begin
                    n_gen = mac_y;
                    n_lo  = i_req.range_low;
                    n_hi  = i_req.range_high;
                    n_fsm = S_START;
                end
            end
            S_START: begin
                n_raw = mix;
                if (size == '0) begin
                    n_ranged = mix;
                    n_fsm    = S_OUT;
                end else begin
                    div_start = 1'b1;
                    n_fsm     = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_ranged = DATA_W'(r_lo + div_rem);
                    n_fsm    = S_OUT;
                end
            end
            S_OUT: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_gen <= SEED_ADD;
        end else begin
            r_fsm <= n_fsm;
            r_gen <= n_gen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_raw    <= n_raw;
        r_ranged <= n_ranged;
    end

    assign o_rsp.raw_value    = r_raw;
    assign o_rsp.ranged_value = r_ranged;

endmodule
